>>> rtl/sfd_pkg.sv
// Shared types and pipeline stage numbering for the spring force core.
// No dependencies; imported by spring_force_and_direction_core and the testbench.
package sfd_pkg;

    // Iteration counts of the square-root and divider pipelines.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    // Stage numbers; a stage's register is loaded from the stage before it.
    localparam int ST_IN        = 1;
    localparam int ST_MAX       = 2;
    localparam int ST_ENC       = 3;
    localparam int ST_SHIFT     = 4;
    localparam int ST_SQR       = 5;
    localparam int ST_SUM       = 6;
    localparam int ST_SQRT0     = 7;
    localparam int ST_SQRT_LAST = ST_SQRT0 + SQRT_STEPS - 1;
    localparam int ST_MUL       = ST_SQRT_LAST + 1;
    localparam int ST_NUM       = ST_MUL + 1;
    localparam int ST_DIV0      = ST_NUM + 1;
    localparam int ST_DIV_LAST  = ST_DIV0 + DIV_STEPS - 1;
    localparam int ST_DIFF      = ST_DIV_LAST + 1;
    localparam int ST_KMUL      = ST_DIFF + 1;
    localparam int ST_OUT       = ST_KMUL + 1;

    typedef logic signed [31:0] coord_t;
    typedef logic [31:0]        ucoord_t;

    // Side data that travels along the pipeline with each spring.
    typedef struct packed {
        logic [2:0][32:0] x;
        logic [31:0]      k;
        logic [31:0]      r;
        logic             degen;
        logic [2:0][30:0] nm;
        logic [31:0]      norm;
    } side_t;

endpackage

>>> rtl/spring_force_and_direction_core.sv
// Hooke spring force and rest-length direction core, fully pipelined.
// Depends on sfd_pkg for types and stage numbering.
//
// Usage: drive the two node positions, stiffness and rest length, and
// raise start for one cycle per spring. busy is always low, so a transfer
// takes place at every rising edge with start high: one spring per cycle.
// The result appears on the force, rest_dir, degenerate and saturated
// ports for exactly one cycle, marked by done. The stages are the
// 32-step square-root pipeline and the 32-step restoring divider, one
// step per stage, plus eleven other stages.
// Results leave in the order springs entered; the receiver cannot stall,
// so no result is ever held back.
// Reset clears all valid bits at once; springs in flight are dropped and
// no done pulse follows until a new spring enters.
module spring_force_and_direction_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sfd_pkg::coord_t  node_a_x,
    input  sfd_pkg::coord_t  node_a_y,
    input  sfd_pkg::coord_t  node_a_z,
    input  sfd_pkg::coord_t  node_b_x,
    input  sfd_pkg::coord_t  node_b_y,
    input  sfd_pkg::coord_t  node_b_z,
    input  sfd_pkg::ucoord_t stiffness,
    input  sfd_pkg::ucoord_t rest_length,
    output logic            done,
    output sfd_pkg::coord_t  force_x,
    output sfd_pkg::coord_t  force_y,
    output sfd_pkg::coord_t  force_z,
    output sfd_pkg::coord_t  rest_dir_x,
    output sfd_pkg::coord_t  rest_dir_y,
    output sfd_pkg::coord_t  rest_dir_z,
    output logic            degenerate,
    output logic            saturated
);
    import sfd_pkg::*;

    localparam int NS = ST_OUT;

    // Valid bits and side data.
    logic  vld_reg [1:NS];
    side_t side_reg [1:ST_DIV_LAST];
    side_t side_next [1:ST_DIV_LAST];

    // Front-end stage registers.
    logic [2:0][31:0] mag1_reg, mag2_reg, mag3_reg;
    logic [31:0]      m2_reg;
    logic [4:0]       left3_reg;
    logic             right3_reg;
    logic [2:0][61:0] sq5_reg;
    logic [63:0]      sum6_reg;

    // Square-root pipeline.
    logic [63:0] sqn_reg [SQRT_STEPS];
    logic [63:0] sqr_reg [SQRT_STEPS];
    logic [63:0] sqn_next [SQRT_STEPS];
    logic [63:0] sqr_next [SQRT_STEPS];

    // Numerator and divider pipeline.
    logic [2:0][62:0] prod_reg;
    logic [2:0][63:0] num_reg;
    logic [2:0][31:0] rem_reg [DIV_STEPS];
    logic [2:0][31:0] low_reg [DIV_STEPS];
    logic [2:0][31:0] rem_next [DIV_STEPS];
    logic [2:0][31:0] low_next [DIV_STEPS];

    // Back-end stage registers.
    logic [2:0][33:0] d_diff_reg, d_kmul_reg;
    logic [2:0][32:0] dm_reg;
    logic [2:0]       dneg_diff_reg, dneg_kmul_reg;
    logic             degen_diff_reg, degen_kmul_reg;
    logic [15:0]      kh_reg, kl_reg;
    logic [2:0][48:0] ph_reg, pl_reg;

    // Combinational helpers.
    logic [2:0][32:0] x_in;
    logic [2:0][31:0] mag_in;
    logic [31:0]      m_max;
    logic [4:0]       lead_pos;
    logic [4:0]       left_amt;
    logic             right_amt;
    logic [2:0][30:0] nm_shift;
    logic [2:0][33:0] d_val;
    logic [2:0][33:0] diff_val;
    logic [2:0][32:0] dm_val;
    logic [2:0][31:0] force_val, dir_val;
    logic [5:0]       sat_bits;

    // Clip a magnitude with a sign to 32-bit signed; bit 32 flags a clip.
    function automatic logic [32:0] clip32(input logic [49:0] mag, input logic neg);
        logic [32:0] res;
        if (neg) begin
            if (mag > 50'h0_8000_0000) begin
                res = {1'b1, 32'h8000_0000};
            end
            else begin
                res = {1'b0, 32'(~mag[31:0] + 32'd1)};
            end
        end
        else begin
            if (mag > 50'h0_7FFF_FFFF) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end
            else begin
                res = {1'b0, mag[31:0]};
            end
        end
        return res;
    endfunction

    assign busy = 1'b0;
    assign done = vld_reg[NS];

    // Separation vector and its per-axis magnitude.
    always_comb
    begin
        x_in[0] = {node_a_x[31], node_a_x} - {node_b_x[31], node_b_x};
        x_in[1] = {node_a_y[31], node_a_y} - {node_b_y[31], node_b_y};
        x_in[2] = {node_a_z[31], node_a_z} - {node_b_z[31], node_b_z};
        for (int i = 0; i < 3; i++) begin
            mag_in[i] = x_in[i][32] ? 32'(~x_in[i] + 33'd1) : x_in[i][31:0];
        end
    end

    // Largest magnitude.
    always_comb
    begin
        m_max = mag1_reg[0];
        if (mag1_reg[1] > m_max) begin
            m_max = mag1_reg[1];
        end
        if (mag1_reg[2] > m_max) begin
            m_max = mag1_reg[2];
        end
    end

    // Leading-one position and normalizing shift.
    always_comb
    begin
        lead_pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (m2_reg[i]) begin
                lead_pos = 5'(i);
            end
        end
        right_amt = m2_reg[31];
        left_amt  = m2_reg[31] ? 5'd0 : 5'(5'd30 - lead_pos);
    end

    // Shift all magnitudes together.
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            if (right3_reg) begin
                nm_shift[i] = mag3_reg[i][31:1];
            end
            else begin
                nm_shift[i] = 31'(mag3_reg[i] << left3_reg);
            end
        end
    end

    // Side data: copy forward, overwriting fields where they are produced.
    always_comb
    begin
        side_next[ST_IN].x     = x_in;
        side_next[ST_IN].k     = stiffness;
        side_next[ST_IN].r     = rest_length;
        side_next[ST_IN].degen = 1'b0;
        side_next[ST_IN].nm    = '0;
        side_next[ST_IN].norm  = '0;
        for (int s = ST_IN + 1; s <= ST_DIV_LAST; s++) begin
            side_next[s] = side_reg[s - 1];
        end
        side_next[ST_MAX].degen = (m_max == 32'd0);
        side_next[ST_SHIFT].nm  = nm_shift;
        side_next[ST_MUL].norm  = sqr_reg[SQRT_STEPS - 1][31:0];
    end

    // One result bit of the square root per stage.
    always_comb
    begin
        logic [63:0] n_in, res_in, bit_val, trial;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            n_in    = (j == 0) ? sum6_reg : sqn_reg[j - 1];
            res_in  = (j == 0) ? 64'd0 : sqr_reg[j - 1];
            bit_val = 64'd1 << (62 - 2 * j);
            trial   = res_in + bit_val;
            if (n_in >= trial) begin
                sqn_next[j] = n_in - trial;
                sqr_next[j] = (res_in >> 1) + bit_val;
            end
            else begin
                sqn_next[j] = n_in;
                sqr_next[j] = res_in >> 1;
            end
        end
    end

    // One quotient bit per stage for each axis.
    always_comb
    begin
        logic [31:0] rem_in, low_in, divisor;
        logic [32:0] rem2;
        logic        ge;
        for (int t = 0; t < DIV_STEPS; t++) begin
            divisor = side_reg[ST_NUM + t].norm;
            for (int i = 0; i < 3; i++) begin
                rem_in = (t == 0) ? num_reg[i][63:32] : rem_reg[t - 1][i];
                low_in = (t == 0) ? num_reg[i][31:0]  : low_reg[t - 1][i];
                rem2   = {rem_in, low_in[31]};
                ge     = (rem2 >= {1'b0, divisor});
                rem_next[t][i] = ge ? 32'(rem2 - {1'b0, divisor}) : rem2[31:0];
                low_next[t][i] = {low_in[30:0], ge};
            end
        end
    end

    // Signed direction and the stretch that drives the force.
    always_comb
    begin
        logic [31:0] q;
        logic [33:0] x_ext;
        for (int i = 0; i < 3; i++) begin
            q     = low_reg[DIV_STEPS - 1][i];
            x_ext = {side_reg[ST_DIV_LAST].x[i][32], side_reg[ST_DIV_LAST].x[i]};
            if (side_reg[ST_DIV_LAST].degen) begin
                d_val[i] = '0;
            end
            else if (side_reg[ST_DIV_LAST].x[i][32]) begin
                d_val[i] = ~{2'b00, q} + 34'd1;
            end
            else begin
                d_val[i] = {2'b00, q};
            end
            diff_val[i] = x_ext - d_val[i];
            dm_val[i]   = diff_val[i][33] ? 33'(~diff_val[i] + 34'd1) : diff_val[i][32:0];
        end
    end

    // Final rounding and saturation.
    always_comb
    begin
        logic [49:0] fm;
        logic [49:0] lo_part;
        logic [32:0] fc, dc;
        logic [33:0] dmag;
        for (int i = 0; i < 3; i++) begin
            lo_part = ({1'b0, pl_reg[i]} + 50'h8000) >> 16;
            fm      = {1'b0, ph_reg[i]} + lo_part;
            fc      = clip32(fm, !dneg_kmul_reg[i] && (fm != 50'd0));
            dmag    = d_kmul_reg[i][33] ? (~d_kmul_reg[i] + 34'd1) : d_kmul_reg[i];
            dc      = clip32({16'd0, dmag}, d_kmul_reg[i][33]);
            force_val[i]    = fc[31:0];
            dir_val[i]      = dc[31:0];
            sat_bits[i]     = fc[32];
            sat_bits[3 + i] = dc[32];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 1; s <= NS; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end
        else begin
            vld_reg[1] <= start && !busy;
            for (int s = 2; s <= NS; s++) begin
                vld_reg[s] <= vld_reg[s - 1];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int s = 1; s <= ST_DIV_LAST; s++) begin
            side_reg[s] <= side_next[s];
        end
        mag1_reg   <= mag_in;
        mag2_reg   <= mag1_reg;
        m2_reg     <= m_max;
        mag3_reg   <= mag2_reg;
        left3_reg  <= left_amt;
        right3_reg <= right_amt;
        for (int i = 0; i < 3; i++) begin
            sq5_reg[i]  <= {31'd0, side_reg[ST_SHIFT].nm[i]} * {31'd0, side_reg[ST_SHIFT].nm[i]};
            prod_reg[i] <= {31'd0, side_reg[ST_SQRT_LAST].r}
                           * {32'd0, side_reg[ST_SQRT_LAST].nm[i]};
            num_reg[i]  <= {1'b0, prod_reg[i]} + {33'd0, side_reg[ST_MUL].norm[31:1]};
        end
        sum6_reg <= {2'b00, sq5_reg[0]} + {2'b00, sq5_reg[1]} + {2'b00, sq5_reg[2]};
        for (int j = 0; j < SQRT_STEPS; j++) begin
            sqn_reg[j] <= sqn_next[j];
            sqr_reg[j] <= sqr_next[j];
        end
        for (int t = 0; t < DIV_STEPS; t++) begin
            rem_reg[t] <= rem_next[t];
            low_reg[t] <= low_next[t];
        end
        d_diff_reg     <= d_val;
        dm_reg         <= dm_val;
        degen_diff_reg <= side_reg[ST_DIV_LAST].degen;
        kh_reg         <= side_reg[ST_DIV_LAST].k[31:16];
        kl_reg         <= side_reg[ST_DIV_LAST].k[15:0];
        for (int i = 0; i < 3; i++) begin
            dneg_diff_reg[i] <= diff_val[i][33];
            ph_reg[i] <= {33'd0, kh_reg} * {16'd0, dm_reg[i]};
            pl_reg[i] <= {33'd0, kl_reg} * {16'd0, dm_reg[i]};
        end
        d_kmul_reg     <= d_diff_reg;
        dneg_kmul_reg  <= dneg_diff_reg;
        degen_kmul_reg <= degen_diff_reg;
        force_x        <= force_val[0];
        force_y        <= force_val[1];
        force_z        <= force_val[2];
        rest_dir_x     <= dir_val[0];
        rest_dir_y     <= dir_val[1];
        rest_dir_z     <= dir_val[2];
        degenerate     <= degen_kmul_reg;
        saturated      <= |sat_bits;
    end

`ifndef SYNTHESIS
    // A result only leaves for a spring that entered the full latency earlier.
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, NS))
        else $error("result without a matching transfer in");

    // Coinciding nodes give a zero direction and zero force.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (rest_dir_x == 0 && rest_dir_y == 0 && rest_dir_z == 0
            && force_x == 0 && force_y == 0 && force_z == 0))
        else $error("degenerate spring with nonzero outputs");

    // Coinciding nodes never clip.
    a_degen_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> !saturated)
        else $error("degenerate spring flagged as saturated");
`endif

endmodule

>>> dv/tb.sv
// Testbench for spring_force_and_direction_core: directed table, then random springs.
// Depends on sfd_pkg and the core RTL; results are checked against typed rows or an internal predictor.
module tb;
    import sfd_pkg::*;

    typedef struct {
        coord_t  ax, ay, az, bx, by, bz;
        ucoord_t k, r;
    } spring_t;

    typedef struct {
        coord_t fx, fy, fz, dx, dy, dz;
        logic   degen, sat;
    } spring_res_t;

    typedef struct {
        spring_t     s;
        bit          typed;
        spring_res_t res;
    } row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    coord_t  node_a_x, node_a_y, node_a_z, node_b_x, node_b_y, node_b_z;
    ucoord_t stiffness, rest_length;
    logic    done;
    coord_t  force_x, force_y, force_z, rest_dir_x, rest_dir_y, rest_dir_z;
    logic    degenerate, saturated;

    spring_res_t expected_forces[$];
    int          errors;
    int          cycles;
    int          sent;
    int          checked;
    int          degen_seen;
    int          sat_seen;

    spring_force_and_direction_core i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .node_a_x(node_a_x), .node_a_y(node_a_y), .node_a_z(node_a_z),
        .node_b_x(node_b_x), .node_b_y(node_b_y), .node_b_z(node_b_z),
        .stiffness(stiffness), .rest_length(rest_length),
        .done(done),
        .force_x(force_x), .force_y(force_y), .force_z(force_z),
        .rest_dir_x(rest_dir_x), .rest_dir_y(rest_dir_y), .rest_dir_z(rest_dir_z),
        .degenerate(degenerate), .saturated(saturated)
    );

    // Clock with a period of 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Integer square root, floor.
    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Clip a magnitude with sign into 32-bit signed range.
    function automatic coord_t clip_q16(logic [63:0] mag, bit neg, ref bit sat);
        if (neg)
        begin
            if (mag > 64'h8000_0000)
            begin
                sat = 1;
                return 32'h8000_0000;
            end
            return coord_t'(-mag);
        end
        if (mag > 64'h7FFF_FFFF)
        begin
            sat = 1;
            return 32'h7FFF_FFFF;
        end
        return coord_t'(mag);
    endfunction

    // Force and rest direction of one spring.
    function automatic spring_res_t hooke_force(spring_t s);
        spring_res_t      o;
        logic signed [63:0] sep[3];
        logic signed [63:0] dir[3];
        logic signed [63:0] diff;
        logic [63:0]      mag[3];
        logic [63:0]      nm[3];
        logic [63:0]      top, sq, norm, q, dm, fm;
        bit               neg[3];
        bit               sat;
        bit               dneg;
        coord_t           f[3];
        coord_t           dv[3];
        sep[0] = 64'(s.ax) - 64'(s.bx);
        sep[1] = 64'(s.ay) - 64'(s.by);
        sep[2] = 64'(s.az) - 64'(s.bz);
        top = 0;
        sq = 0;
        sat = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = sep[i] < 0;
            mag[i] = neg[i] ? 64'(-sep[i]) : 64'(sep[i]);
            if (mag[i] > top)
                top = mag[i];
            dir[i] = 0;
            nm[i] = mag[i];
        end
        o.degen = (top == 0);
        if (!o.degen)
        begin
            // Bring the largest component into [2^30, 2^31).
            while (top < (64'd1 << 30))
            begin
                top = top << 1;
                for (int i = 0; i < 3; i++)
                    nm[i] = nm[i] << 1;
            end
            while (top >= (64'd1 << 31))
            begin
                top = top >> 1;
                for (int i = 0; i < 3; i++)
                    nm[i] = nm[i] >> 1;
            end
            for (int i = 0; i < 3; i++)
                sq = sq + nm[i] * nm[i];
            norm = floor_sqrt(sq);
            for (int i = 0; i < 3; i++)
            begin
                q = (64'(s.r) * nm[i] + (norm >> 1)) / norm;
                dir[i] = neg[i] ? -$signed(q) : $signed(q);
            end
        end
        // Force uses the unclipped direction.
        for (int i = 0; i < 3; i++)
        begin
            diff = sep[i] - dir[i];
            dneg = diff < 0;
            dm = dneg ? 64'(-diff) : 64'(diff);
            fm = 64'(s.k[31:16]) * dm + ((64'(s.k[15:0]) * dm + 64'h8000) >> 16);
            f[i] = clip_q16(fm, !dneg && fm != 0, sat);
        end
        for (int i = 0; i < 3; i++)
        begin
            dm = (dir[i] < 0) ? 64'(-dir[i]) : 64'(dir[i]);
            dv[i] = clip_q16(dm, dir[i] < 0, sat);
        end
        o.fx = f[0];
        o.fy = f[1];
        o.fz = f[2];
        o.dx = dv[0];
        o.dy = dv[1];
        o.dz = dv[2];
        o.sat = sat;
        return o;
    endfunction

    // Drive one spring and hold it until the transfer takes place.
    task automatic send_spring(spring_t s, spring_res_t res);
        node_a_x <= s.ax;
        node_a_y <= s.ay;
        node_a_z <= s.az;
        node_b_x <= s.bx;
        node_b_y <= s.by;
        node_b_z <= s.bz;
        stiffness <= s.k;
        rest_length <= s.r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_forces.insert(expected_forces.size(), res);
        sent++;
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
            2: return coord_t'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
            default: return coord_t'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
        endcase
    endfunction

    function automatic spring_t rand_spring();
        spring_t s;
        s.ax = rand_coord();
        s.ay = rand_coord();
        s.az = rand_coord();
        // Node b is often close to node a, sometimes identical.
        case ($urandom_range(0, 9))
            0:
            begin
                s.bx = s.ax;
                s.by = s.ay;
                s.bz = s.az;
            end
            1, 2, 3, 4, 5:
            begin
                s.bx = s.ax + coord_t'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
                s.by = s.ay + coord_t'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
                s.bz = s.az + coord_t'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
            end
            default:
            begin
                s.bx = rand_coord();
                s.by = rand_coord();
                s.bz = rand_coord();
            end
        endcase
        s.k = ($urandom_range(0, 3) == 0) ? ucoord_t'($urandom) : ucoord_t'($urandom_range(0, 32'h20_0000));
        s.r = ($urandom_range(0, 3) == 0) ? ucoord_t'($urandom) : ucoord_t'($urandom_range(0, 32'h4_0000));
        return s;
    endfunction

    // Compare every result against the oldest expectation.
    always @(posedge clk)
    begin
        spring_res_t e;
        if (rst_n && done)
        begin
            if (expected_forces.size() == 0)
            begin
                $error("result with no spring outstanding");
                errors++;
            end
            else
            begin
                e = expected_forces.pop_front();
                checked++;
                if (degenerate === 1'b1)
                    degen_seen++;
                if (saturated === 1'b1)
                    sat_seen++;
                if (force_x !== e.fx)
                begin
                    $error("force_x expected %0d got %0d", e.fx, force_x);
                    errors++;
                end
                if (force_y !== e.fy)
                begin
                    $error("force_y expected %0d got %0d", e.fy, force_y);
                    errors++;
                end
                if (force_z !== e.fz)
                begin
                    $error("force_z expected %0d got %0d", e.fz, force_z);
                    errors++;
                end
                if (rest_dir_x !== e.dx)
                begin
                    $error("rest_dir_x expected %0d got %0d", e.dx, rest_dir_x);
                    errors++;
                end
                if (rest_dir_y !== e.dy)
                begin
                    $error("rest_dir_y expected %0d got %0d", e.dy, rest_dir_y);
                    errors++;
                end
                if (rest_dir_z !== e.dz)
                begin
                    $error("rest_dir_z expected %0d got %0d", e.dz, rest_dir_z);
                    errors++;
                end
                if (degenerate !== e.degen)
                begin
                    $error("degenerate expected %0b got %0b", e.degen, degenerate);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %0b got %0b", e.sat, saturated);
                    errors++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 200000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        row_t        rows[$];
        row_t        row;
        spring_res_t zero_res;
        spring_t     s;
        int          burst;
        int          drain;

        errors = 0;
        cycles = 0;
        sent = 0;
        checked = 0;
        degen_seen = 0;
        sat_seen = 0;
        rst_n = 1'b0;
        start = 1'b0;
        node_a_x = '0;
        node_a_y = '0;
        node_a_z = '0;
        node_b_x = '0;
        node_b_y = '0;
        node_b_z = '0;
        stiffness = '0;
        rest_length = '0;

        zero_res = '{fx: 0, fy: 0, fz: 0, dx: 0, dy: 0, dz: 0, degen: 1'b1, sat: 1'b0};

        // Directed table; typed results only where they are obvious.
        // Coinciding nodes: all zero, degenerate set.
        row = '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'h0001_0000}, 1, zero_res};
        rows.insert(rows.size(), row);
        // Largest separation with maximum stiffness and zero rest length saturates.
        row = '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 0}, 1,
                '{fx: 32'h8000_0000, fy: 32'h8000_0000, fz: 32'h7FFF_FFFF,
                  dx: 0, dy: 0, dz: 0, degen: 1'b0, sat: 1'b1}};
        rows.insert(rows.size(), row);
        // Zero stiffness and zero rest length: no force, no direction.
        row = '{'{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                  0, 0, 0, 0, 0}, 1,
                '{fx: 0, fy: 0, fz: 0, dx: 0, dy: 0, dz: 0,
                  degen: 1'b0, sat: 1'b0}};
        rows.insert(rows.size(), row);
        // Remaining rows go through the predictor.
        row = '{'{32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000}, 0, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{0, 32'h0003_0000, 0, 0, 0, 0, 32'h0002_0000, 32'h0001_0000}, 0, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{0, 0, 1, 0, 0, 0, 32'h0001_0000, 32'h0001_0000}, 0, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0,
                  32'h000A_0000, 32'h0002_0000}, 0, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h0000_0001, 32'hFFFF_FFFF}, 0, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{1, 1, 1, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{32'hFFFF_FFFF, 0, 0, 0, 0, 0, 32'h0000_8000, 32'h0000_8000}, 0, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC,
                  32'h5555_5555, 32'hAAAA_AAAA}, 0, zero_res};
        rows.insert(rows.size(), row);
        row = '{'{0, 0, 0, 0, 0, 32'h0000_0002,
                  32'h0001_0000, 32'h8000_0000}, 0, zero_res};
        rows.insert(rows.size(), row);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back.
        foreach (rows[i])
        begin
            row = rows[i];
            send_spring(row.s, row.typed ? row.res : hooke_force(row.s));
        end

        // Random part in bursts with gaps.
        while (sent < 1214)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++)
            begin
                s = rand_spring();
                send_spring(s, hooke_force(s));
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 90));
        end
        start <= 1'b0;

        // Drain the pipeline, then let it settle.
        drain = 0;
        while (expected_forces.size() != 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (100) @(posedge clk);

        $display("Sent %0d springs, checked %0d results (%0d degenerate, %0d saturated).",
                 sent, checked, degen_seen, sat_seen);
        if (errors == 0 && expected_forces.size() == 0)
            $display("CHECK OK");
        else
        begin
            if (expected_forces.size() != 0)
                $error("%0d results never arrived", expected_forces.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
